// ===== rtl/assert_macros.svh =====
// Assertion helpers; the enclosing module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define CHK_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/wbpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wbpm_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int MAX_TABLE_DIST = 17;

	localparam int DIST_W = 5;
	localparam int TGT_W  = 16;
	localparam int MULT_W = 10;
	localparam int ERR_W  = 17;
	localparam int SUM_W  = 32;
	localparam int DER_W  = ERR_W + 1;
	localparam int GAIN_W = 24;
	localparam int BASE_W = 10;
	localparam int PID_W  = 16;
	localparam int FRAC_W = 16;

	// product and accumulator widths (gains are zero-extended to signed)
	localparam int PP_W   = GAIN_W + 1 + ERR_W;
	localparam int PI_W   = GAIN_W + 1 + SUM_W;
	localparam int PD_W   = GAIN_W + 1 + DER_W;
	localparam int PPD_W  = PD_W + 1;
	localparam int ACC_W  = PI_W + 1;
	localparam int QUO_W  = ACC_W - FRAC_W;
	localparam int DRV_W  = PID_W + 2;

	localparam int ERR_MAX_VAL = 2 ** (ERR_W - 1) - 1;
	localparam int ERR_MIN_VAL = -(2 ** (ERR_W - 1));
	localparam int PID_MAX_VAL = 2 ** (PID_W - 1) - 1;
	localparam int PID_MIN_VAL = -(2 ** (PID_W - 1));
	localparam int DRIVE_LIMIT = 400;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = GAIN_W;

	localparam logic [GAIN_W-1:0] GAIN_P_RST = GAIN_W'(121242);
	localparam logic [GAIN_W-1:0] GAIN_I_RST = GAIN_W'(20);
	localparam logic [GAIN_W-1:0] GAIN_D_RST = GAIN_W'(3129672);
	localparam logic signed [BASE_W-1:0] RIGHT_BASE_RST = BASE_W'(250);
	localparam logic signed [BASE_W-1:0] LEFT_BASE_RST  = BASE_W'(380);

	// ticks per grid unit
	localparam int MULT_SHORT = 537;
	localparam int MULT_TWO   = 560;
	localparam int MULT_FEW   = 580;
	localparam int MULT_MID   = 590;
	localparam int MULT_LONG  = 600;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P     = 3'd0,
		REG_GAIN_I     = 3'd1,
		REG_GAIN_D     = 3'd2,
		REG_RIGHT_BASE = 3'd3,
		REG_LEFT_BASE  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BRAKE = 2'd1,
		OP_PID   = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t                 kind;
		logic signed [ERR_W-1:0]  err;
	} q_item_t;

	typedef struct packed {
		logic [GAIN_W-1:0]        gain_p;
		logic [GAIN_W-1:0]        gain_i;
		logic [GAIN_W-1:0]        gain_d;
		logic signed [BASE_W-1:0] right_base;
		logic signed [BASE_W-1:0] left_base;
	} cfg_t;

	function automatic logic [MULT_W-1:0] tick_mult(input logic [DIST_W-1:0] d);
		int dv;
		logic [MULT_W-1:0] m;
		dv = int'(d);
		if (dv < 1 || dv > MAX_TABLE_DIST)
			m = MULT_W'(MULT_SHORT);
		else if (dv == 1)
			m = MULT_W'(MULT_SHORT);
		else if (dv == 2)
			m = MULT_W'(MULT_TWO);
		else if (dv <= 4)
			m = MULT_W'(MULT_FEW);
		else if (dv <= 9)
			m = MULT_W'(MULT_MID);
		else
			m = MULT_W'(MULT_LONG);
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/wbpm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wbpm_front import wbpm_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  cmd,
	input  wire logic [DIST_W-1:0]     distance,
	input  wire logic [COUNT_BITS-1:0] left_count,
	input  wire logic [COUNT_BITS-1:0] right_count,
	input  wire logic                  q_full,
	output logic                       push,
	output q_item_t                    push_item
);

	localparam int DW = (COUNT_BITS + 1 > ERR_W) ? COUNT_BITS + 1 : ERR_W;
	localparam int CW = (COUNT_BITS > TGT_W) ? COUNT_BITS : TGT_W;
	localparam logic signed [DW-1:0] EMAX = DW'(ERR_MAX_VAL);
	localparam logic signed [DW-1:0] EMIN = DW'(ERR_MIN_VAL);

	logic [TGT_W-1:0]              target_q;
	logic [MULT_W+DIST_W-1:0]      tgt_full;
	logic signed [DW-1:0]          diff;
	logic signed [ERR_W-1:0]       err_c;
	logic                          past_target;

	assign tgt_full = {{DIST_W{1'b0}}, tick_mult(distance)} * {{MULT_W{1'b0}}, distance};
	assign diff = $signed(DW'(right_count)) - $signed(DW'(left_count));
	assign past_target = CW'(right_count) > CW'(target_q);

	always_comb begin
		if (diff > EMAX)
			err_c = ERR_W'(ERR_MAX_VAL);
		else if (diff < EMIN)
			err_c = ERR_W'(ERR_MIN_VAL);
		else
			err_c = $signed(diff[ERR_W-1:0]);
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_item.err = err_c;
		if (cmd == CMD_START)
			push_item.kind = OP_START;
		else if (past_target)
			push_item.kind = OP_BRAKE;
		else
			push_item.kind = OP_PID;
	end

	// target is front state so the brake decision follows the item order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (push && cmd == CMD_START) begin
			target_q <= TGT_W'(tgt_full);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/wbpm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wbpm_queue import wbpm_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  q_item_t      push_item,
	output logic         full,
	input  wire logic    pop,
	output q_item_t      pop_item,
	output logic         not_empty
);

	q_item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_PTR_W:0]     count_q;

	assign full      = count_q == (Q_PTR_W + 1)'(Q_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/wbpm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wbpm_back import wbpm_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  cfg_t                     cfg,
	input  wire logic                q_valid,
	input  q_item_t                  q_item,
	output logic                     q_pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [BASE_W-1:0] right_drive,
	output logic signed [BASE_W-1:0] left_drive,
	output logic signed [PID_W-1:0]  pid_term,
	output logic                     done_res
);

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic signed [QUO_W-1:0] PMAX = QUO_W'(PID_MAX_VAL);
	localparam logic signed [QUO_W-1:0] PMIN = QUO_W'(PID_MIN_VAL);
	localparam logic signed [DRV_W-1:0] LIM_HI = DRV_W'(DRIVE_LIMIT);
	localparam logic signed [DRV_W-1:0] LIM_LO = DRV_W'(-DRIVE_LIMIT);

	// loop-carried state: integral and previous error
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [ERR_W-1:0]  last_q;

	logic signed [ERR_W-1:0]  err_in;
	logic signed [SUM_W:0]    sum_wide;
	logic signed [SUM_W-1:0]  sum_nxt;
	logic signed [DER_W-1:0]  der_nxt;

	logic                     v1_q, v2_q, v3_q, v4_q, v5_q;
	logic                     rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;

	op_kind_t                 kind_s1, kind_s2, kind_s3, kind_s4, kind_s5;
	logic signed [ERR_W-1:0]  err_s1;
	logic signed [SUM_W-1:0]  sum_s1;
	logic signed [DER_W-1:0]  der_s1;
	logic signed [PP_W-1:0]   prod_p_s2;
	logic signed [PI_W-1:0]   prod_i_s2;
	logic signed [PD_W-1:0]   prod_d_s2;
	logic signed [PPD_W-1:0]  ppd_s3;
	logic signed [PI_W-1:0]   prod_i_s3;
	logic signed [ACC_W-1:0]  acc_s4;
	logic signed [PID_W-1:0]  pid_s5;

	logic signed [QUO_W-1:0]  quo;
	logic signed [QUO_W-1:0]  quo_tz;
	logic signed [PID_W-1:0]  pid_sat;
	logic signed [DRV_W-1:0]  rd_wide;
	logic signed [DRV_W-1:0]  ld_wide;
	logic signed [BASE_W-1:0] rd_sat;
	logic signed [BASE_W-1:0] ld_sat;

	// each stage takes a new transaction when empty or when its own moves on
	assign rdy_o = !out_valid || !out_stall;
	assign rdy5  = !v5_q || rdy_o;
	assign rdy4  = !v4_q || rdy5;
	assign rdy3  = !v3_q || rdy4;
	assign rdy2  = !v2_q || rdy3;
	assign rdy1  = !v1_q || rdy2;
	assign q_pop = q_valid && rdy1;

	assign err_in   = $signed(q_item.err);
	assign sum_wide = $signed({sum_q[SUM_W-1], sum_q}) + (SUM_W + 1)'(err_in);
	assign der_nxt  = DER_W'(err_in) - DER_W'(last_q);

	always_comb begin
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
			sum_nxt = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
		else
			sum_nxt = sum_wide[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			last_q <= '0;
		end else if (q_pop) begin
			case (q_item.kind)
				OP_START: begin
					sum_q <= '0;
				end
				OP_PID: begin
					sum_q  <= sum_nxt;
					last_q <= err_in;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q      <= 1'b0;
			v2_q      <= 1'b0;
			v3_q      <= 1'b0;
			v4_q      <= 1'b0;
			v5_q      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rdy1)
				v1_q <= q_pop;
			if (rdy2)
				v2_q <= v1_q;
			if (rdy3)
				v3_q <= v2_q;
			if (rdy4)
				v4_q <= v3_q;
			if (rdy5)
				v5_q <= v4_q;
			if (rdy_o)
				out_valid <= v5_q;
		end
	end

	// truncate Q.16 toward zero, then saturate
	assign quo    = acc_s4[ACC_W-1:FRAC_W];
	assign quo_tz = (acc_s4[ACC_W-1] && (|acc_s4[FRAC_W-1:0])) ? quo + 1'b1 : quo;

	always_comb begin
		if (quo_tz > PMAX)
			pid_sat = PID_W'(PID_MAX_VAL);
		else if (quo_tz < PMIN)
			pid_sat = PID_W'(PID_MIN_VAL);
		else
			pid_sat = quo_tz[PID_W-1:0];
	end

	assign rd_wide = DRV_W'(cfg.right_base) - DRV_W'(pid_s5);
	assign ld_wide = DRV_W'(cfg.left_base);

	always_comb begin
		if (rd_wide > LIM_HI)
			rd_sat = BASE_W'(DRIVE_LIMIT);
		else if (rd_wide < LIM_LO)
			rd_sat = BASE_W'(-DRIVE_LIMIT);
		else
			rd_sat = rd_wide[BASE_W-1:0];
		if (ld_wide > LIM_HI)
			ld_sat = BASE_W'(DRIVE_LIMIT);
		else if (ld_wide < LIM_LO)
			ld_sat = BASE_W'(-DRIVE_LIMIT);
		else
			ld_sat = ld_wide[BASE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_s1 <= q_item.kind;
			err_s1  <= err_in;
			sum_s1  <= sum_nxt;
			der_s1  <= der_nxt;
		end
		if (rdy2 && v1_q) begin
			kind_s2   <= kind_s1;
			prod_p_s2 <= $signed({1'b0, cfg.gain_p}) * err_s1;
			prod_i_s2 <= $signed({1'b0, cfg.gain_i}) * sum_s1;
			prod_d_s2 <= $signed({1'b0, cfg.gain_d}) * der_s1;
		end
		if (rdy3 && v2_q) begin
			kind_s3   <= kind_s2;
			ppd_s3    <= PPD_W'(prod_p_s2) + PPD_W'(prod_d_s2);
			prod_i_s3 <= prod_i_s2;
		end
		if (rdy4 && v3_q) begin
			kind_s4 <= kind_s3;
			acc_s4  <= ACC_W'(ppd_s3) + ACC_W'(prod_i_s3);
		end
		if (rdy5 && v4_q) begin
			kind_s5 <= kind_s4;
			pid_s5  <= (kind_s4 == OP_PID) ? pid_sat : '0;
		end
		if (rdy_o && v5_q) begin
			case (kind_s5)
				OP_PID: begin
					right_drive <= rd_sat;
					left_drive  <= ld_sat;
					pid_term    <= pid_s5;
					done_res    <= 1'b0;
				end
				OP_BRAKE: begin
					right_drive <= '0;
					left_drive  <= '0;
					pid_term    <= '0;
					done_res    <= 1'b1;
				end
				default: begin
					right_drive <= '0;
					left_drive  <= '0;
					pid_term    <= '0;
					done_res    <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/wheel_balance_pid_move.sv =====
// An accepted transaction passes the queue write, then 5 back-end stages, then the output
// register. Throughput: one transaction per cycle while out_stall and a full queue do not
// hold the flow; the integral and last-error update is made as the first back-end stage
// takes each transaction. A 4-entry queue decouples front/back.
// Reset (arst_n low): pipeline and queue empty, target, integral and last error
// cleared, gains and base drives back to their defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wheel_balance_pid_move import wbpm_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  cmd,
	input  wire logic [DIST_W-1:0]     distance,
	input  wire logic [COUNT_BITS-1:0] left_count,
	input  wire logic [COUNT_BITS-1:0] right_count,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [BASE_W-1:0]   right_drive,
	output logic signed [BASE_W-1:0]   left_drive,
	output logic signed [PID_W-1:0]    pid_term,
	output logic                       done_res
);

	cfg_t     cfg_q;
	logic     q_full;
	logic     q_valid;
	logic     push;
	logic     pop;
	q_item_t  push_item;
	q_item_t  pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p     <= GAIN_P_RST;
			cfg_q.gain_i     <= GAIN_I_RST;
			cfg_q.gain_d     <= GAIN_D_RST;
			cfg_q.right_base <= RIGHT_BASE_RST;
			cfg_q.left_base  <= LEFT_BASE_RST;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIN_P:     cfg_q.gain_p     <= cfg_data;
				REG_GAIN_I:     cfg_q.gain_i     <= cfg_data;
				REG_GAIN_D:     cfg_q.gain_d     <= cfg_data;
				REG_RIGHT_BASE: cfg_q.right_base <= $signed(cfg_data[BASE_W-1:0]);
				REG_LEFT_BASE:  cfg_q.left_base  <= $signed(cfg_data[BASE_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	wbpm_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.distance    (distance),
		.left_count  (left_count),
		.right_count (right_count),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	wbpm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.not_empty (q_valid)
	);

	wbpm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_item      (pop_item),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.right_drive (right_drive),
		.left_drive  (left_drive),
		.pid_term    (pid_term),
		.done_res    (done_res)
	);

	`CHK_IMPLY(a_brake_zero, out_valid && done_res, right_drive == '0 && left_drive == '0 && pid_term == '0, "braked result with nonzero drive")
	`CHK_IMPLY(a_right_range, out_valid, $signed(right_drive) <= 10'sd400 && $signed(right_drive) >= -10'sd400, "right drive out of range")
	`CHK_IMPLY(a_left_range, out_valid, $signed(left_drive) <= 10'sd400 && $signed(left_drive) >= -10'sd400, "left drive out of range")
	`CHK_NEXT(a_push_lands, in_valid && !in_stall, q_valid, "accepted transaction missing from queue")

endmodule

`default_nettype wire
